// ===== design/sqlts_pkg.sv =====
// Shared types, keyword table and character class helpers for the SQL token scanner.
`timescale 1ns / 1ps
package sqlts_pkg;

    localparam int KW_COUNT     = 36;
    localparam int HASH_BUCKETS = 16;
    localparam int RESULT_CAP   = 64;

    // Token classes as they appear on the result channel.
    typedef enum logic [2:0] {
        TC_KEYWORD  = 3'd0,
        TC_IDENT    = 3'd1,
        TC_INTEGER  = 3'd2,
        TC_REAL     = 3'd3,
        TC_TEXT     = 3'd4,
        TC_CHAR     = 3'd5,
        TC_END      = 3'd6,
        TC_OVERFLOW = 3'd7
    } t_tok_class;

    // Lexical state of the token being built.
    typedef enum logic [3:0] {
        SC_START   = 4'd0,
        SC_WORD    = 4'd1,
        SC_IDENT   = 4'd2,
        SC_INT     = 4'd3,
        SC_REAL    = 4'd4,
        SC_SIGN    = 4'd5,
        SC_OP      = 4'd6,
        SC_TEXT    = 4'd7,
        SC_ESC     = 4'd8,
        SC_COMMENT = 4'd9
    } t_scan;

    // Sequencer state around the history memory.
    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_FEED = 2'd1,
        CTL_READ = 2'd2
    } t_ctl;

    // What the scanner does with the byte it just looked at.
    typedef enum logic [1:0] {
        ACT_ADV  = 2'd0,
        ACT_RPT  = 2'd1,
        ACT_FAIL = 2'd2,
        ACT_END  = 2'd3
    } t_act;

    // Request to the keyword matcher: append a byte, or look up at the given length.
    typedef struct packed {
        logic       append;
        logic       first;
        logic [3:0] pos;
        logic [7:0] data;
    } t_kw_req;

    typedef struct packed {
        logic       hit;
        logic [5:0] id;
    } t_kw_res;

    // Keyword and operator strings, right aligned, first character highest.
    localparam logic [63:0] KW_WORD [KW_COUNT] = '{
        "select", "values", "or", "not", "distinct", "and", "delete", "update",
        "from", "create", "primary", "smallint", "real", "drop", "insert", "like",
        "asc", "table", "<=", "all", "key", "<>", "into", "where",
        ">=", "by", "null", "int", "<", "order", "set", "=",
        ">", "integer", "char", "desc"
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd6, 4'd2, 4'd3, 4'd8, 4'd3, 4'd6, 4'd6,
        4'd4, 4'd6, 4'd7, 4'd8, 4'd4, 4'd4, 4'd6, 4'd4,
        4'd3, 4'd5, 4'd2, 4'd3, 4'd3, 4'd2, 4'd4, 4'd5,
        4'd2, 4'd2, 4'd4, 4'd3, 4'd1, 4'd5, 4'd3, 4'd1,
        4'd1, 4'd7, 4'd4, 4'd4
    };

    localparam logic [3:0] KW_BUCKET [KW_COUNT] = '{
        4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd5, 4'd5,
        4'd7, 4'd8, 4'd9, 4'd9, 4'd9, 4'd10, 4'd10, 4'd11,
        4'd11, 4'd11, 4'd11, 4'd11, 4'd12, 4'd12, 4'd12, 4'd13,
        4'd14, 4'd14, 4'd14, 4'd15
    };

    localparam logic [5:0] KW_ID [KW_COUNT] = '{
        6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7,
        6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15,
        6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23,
        6'd24, 6'd25, 6'd26, 6'd11, 6'd27, 6'd28, 6'd29, 6'd30,
        6'd31, 6'd11, 6'd32, 6'd33
    };

    // Character k of table word i; zero past the end of the word.
    function automatic logic [7:0] kw_char(input int i, input logic [2:0] k);
        logic [63:0] w;
        int          l;
        w = KW_WORD[i];
        l = int'(KW_LEN[i]);
        if (int'(k) < l) begin
            return w[8 * (l - 1 - int'(k)) +: 8];
        end
        return 8'd0;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return c == "<" || c == ">" || c == "=";
    endfunction

endpackage

// ===== design/sqlts_kw_match.sv =====
// Incremental case-insensitive keyword matcher with running bucket hash.
`timescale 1ns / 1ps
module sqlts_kw_match
    import sqlts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_kw_req i_req,
    output t_kw_res o_res
);

    logic [KW_COUNT-1:0] r_cand;
    logic [KW_COUNT-1:0] n_cand;
    logic [3:0]          r_sum;
    logic [3:0]          n_sum;
    logic [7:0]          lower;

    // Fold upper case letters onto lower case before comparing.
    always_comb begin
        lower = i_req.data;
        if (i_req.data > 8'd64 && i_req.data < 8'd91) begin
            lower = i_req.data + 8'd32;
        end
    end

    // Each appended byte narrows the set of table words still matching.
    always_comb begin
        for (int i = 0; i < KW_COUNT; i++) begin
            n_cand[i] = (i_req.first | r_cand[i]) & (KW_LEN[i] > i_req.pos)
                        & (kw_char(i, i_req.pos[2:0]) == lower);
        end
        n_sum = (i_req.first ? 4'd0 : r_sum) + i_req.data[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
            r_sum  <= '0;
        end else if (i_req.append) begin
            r_cand <= n_cand;
            r_sum  <= n_sum;
        end
    end

    // First table entry whose length and bucket agree wins.
    always_comb begin
        o_res = '0;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (r_cand[i] && KW_LEN[i] == i_req.pos && KW_BUCKET[i] == r_sum) begin
                o_res.hit = 1'b1;
                o_res.id  = KW_ID[i];
            end
        end
    end

endmodule

// ===== design/sql_token_scanner_unit.sv =====
// Top level of the SQL token scanner: byte history memory, scanner and result staging.
`timescale 1ns / 1ps
// Usage: query bytes enter on the input channel (i_in_valid, o_in_stall), one per
// transfer; i_new_query restarts offset, line count and scan state before the
// byte is scanned, and a zero byte marks end of input. Tokens leave on the
// result channel (o_out_valid, i_out_stall), up to RESULT_CAP per input byte,
// with o_last_result set on the final token that a byte causes.
// Every accepted byte before end of input is written to a history memory indexed
// by its offset. A plain byte is accepted and then scanned. A step that closes a
// token on a byte outside it rescans the same byte; a failed match replays the
// buffered bytes from the memory, each read back and then scanned again.
// The final token of a byte is held in a staging register until the scanner is idle
// and moves to the output register once that is free, when the next byte can be accepted.
// When the receiver stalls, the scanner holds its step until the staging
// register can move on; apart from tokens past RESULT_CAP for one byte, none is lost.
// Reset (synchronous, active low) puts the scanner at the start of a token,
// line 1, offset 0, with both result registers empty. The memory needs no
// clearing: only bytes of the current token are ever read back.
module sql_token_scanner_unit
    import sqlts_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_new_query,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_class,
    output logic [5:0]  o_keyword_id,
    output logic [7:0]  o_char_value,
    output logic [15:0] o_token_start,
    output logic [6:0]  o_token_length,
    output logic [15:0] o_line_number,
    output logic        o_last_result
);

    localparam int FW    = $clog2(MAX_TOKEN_LEN + 1);
    localparam int AW    = $clog2(MAX_TOKEN_LEN + 1);
    localparam int DEPTH = 1 << AW;

    // Byte history and its read port.
    logic [7:0]    r_hist [DEPTH];
    logic [7:0]    r_rd;

    t_ctl          r_ctl;
    t_scan         r_scan;
    logic [FW-1:0] r_fill;
    logic [7:0]    r_first;
    logic [15:0]   r_line;
    logic [15:0]   r_off;
    logic          r_ended;
    logic [15:0]   r_p;
    logic [7:0]    r_byte;
    logic          r_from_mem;
    logic [6:0]    r_res_cnt;

    // Staging register for the newest token of the step.
    logic          r_hold_v;
    logic [2:0]    r_hold_cls;
    logic [5:0]    r_hold_kw;
    logic [7:0]    r_hold_ch;
    logic [15:0]   r_hold_start;
    logic [6:0]    r_hold_len;
    logic [15:0]   r_hold_line;

    logic          r_out_v;
    logic [2:0]    r_out_cls;
    logic [5:0]    r_out_kw;
    logic [7:0]    r_out_ch;
    logic [15:0]   r_out_start;
    logic [6:0]    r_out_len;
    logic [15:0]   r_out_line;
    logic          r_out_last;

    logic          out_free;
    logic          in_acc;
    logic          eff_ended;
    logic [15:0]   eff_off;
    logic [7:0]    c;
    logic [15:0]   st;
    logic [FW+6:0] fill_ext;
    logic          full;

    // Scan step decode.
    logic          f_emit;
    t_tok_class    f_cls;
    logic [5:0]    f_kw;
    logic [7:0]    f_ch;
    logic [15:0]   f_start;
    logic [6:0]    f_len;
    t_act          f_act;
    t_scan         f_scan;
    logic          f_append;
    logic          f_finish;
    logic          f_bump;
    logic          emit_push;
    logic          emit_ok;
    logic          feed_go;
    logic [15:0]   n_p;

    t_kw_req       kw_req;
    t_kw_res       kw_res;

    sqlts_kw_match u_kw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (kw_req),
        .o_res   (kw_res)
    );

    assign out_free   = !r_out_v || !i_out_stall;
    assign o_in_stall = !(r_ctl == CTL_IDLE && (!r_hold_v || out_free));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign eff_ended  = i_new_query ? 1'b0 : r_ended;
    assign eff_off    = i_new_query ? 16'd0 : r_off;

    assign c        = r_from_mem ? r_rd : r_byte;
    assign st       = r_p - 16'(r_fill);
    assign fill_ext = (FW + 7)'(r_fill);
    assign full     = r_fill >= FW'(MAX_TOKEN_LEN);

    // Keyword matcher sees the current fill and the byte being scanned.
    always_comb begin
        kw_req.append = feed_go && f_append;
        kw_req.first  = r_fill == '0;
        kw_req.pos    = (fill_ext > (FW + 7)'(15)) ? 4'd15 : fill_ext[3:0];
        kw_req.data   = c;
    end

    // One scan step on byte c at offset r_p.
    always_comb begin
        f_emit   = 1'b0;
        f_cls    = TC_CHAR;
        f_kw     = '0;
        f_ch     = '0;
        f_start  = st;
        f_len    = fill_ext[6:0];
        f_act    = ACT_ADV;
        f_scan   = r_scan;
        f_append = 1'b0;
        f_finish = 1'b0;
        f_bump   = 1'b0;
        if (r_scan != SC_START && r_scan != SC_COMMENT && full) begin
            // Token longer than the buffer.
            f_emit   = 1'b1;
            f_cls    = TC_OVERFLOW;
            f_finish = 1'b1;
            f_act    = ACT_RPT;
        end else begin
            unique case (r_scan)
                SC_START: begin
                    if (c == " " || c == 8'd9) begin
                        f_act = ACT_ADV;
                    end else if (c == 8'd10) begin
                        f_bump = 1'b1;
                    end else if (c == "'") begin
                        f_append = 1'b1;
                        f_scan   = SC_TEXT;
                    end else if (is_alpha(c)) begin
                        f_append = 1'b1;
                        f_scan   = SC_WORD;
                    end else if (is_digit(c)) begin
                        f_append = 1'b1;
                        f_scan   = SC_INT;
                    end else if (c == "-" || c == "+") begin
                        f_append = 1'b1;
                        f_scan   = SC_SIGN;
                    end else if (is_op(c)) begin
                        f_append = 1'b1;
                        f_scan   = SC_OP;
                    end else if (c == "#") begin
                        f_scan = SC_COMMENT;
                    end else if (c == 8'd0) begin
                        f_emit   = 1'b1;
                        f_cls    = TC_END;
                        f_start  = r_p;
                        f_len    = '0;
                        f_finish = 1'b1;
                        f_act    = ACT_END;
                    end else begin
                        f_emit  = 1'b1;
                        f_cls   = TC_CHAR;
                        f_ch    = c;
                        f_start = r_p;
                        f_len   = 7'd1;
                    end
                end
                SC_WORD: begin
                    if (is_alpha(c)) begin
                        f_append = 1'b1;
                    end else if (is_digit(c) || c == "_") begin
                        f_append = 1'b1;
                        f_scan   = SC_IDENT;
                    end else begin
                        f_emit   = 1'b1;
                        f_cls    = kw_res.hit ? TC_KEYWORD : TC_IDENT;
                        f_kw     = kw_res.hit ? kw_res.id : 6'd0;
                        f_finish = 1'b1;
                        f_act    = ACT_RPT;
                    end
                end
                SC_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        f_append = 1'b1;
                    end else begin
                        f_emit   = 1'b1;
                        f_cls    = TC_IDENT;
                        f_finish = 1'b1;
                        f_act    = ACT_RPT;
                    end
                end
                SC_INT: begin
                    if (is_digit(c)) begin
                        f_append = 1'b1;
                    end else if (c == ".") begin
                        f_append = 1'b1;
                        f_scan   = SC_REAL;
                    end else begin
                        f_emit   = 1'b1;
                        f_cls    = TC_INTEGER;
                        f_finish = 1'b1;
                        f_act    = ACT_RPT;
                    end
                end
                SC_REAL: begin
                    if (is_digit(c)) begin
                        f_append = 1'b1;
                    end else begin
                        f_emit   = 1'b1;
                        f_cls    = TC_REAL;
                        f_finish = 1'b1;
                        f_act    = ACT_RPT;
                    end
                end
                SC_SIGN: begin
                    if (is_digit(c)) begin
                        f_append = 1'b1;
                        f_scan   = SC_INT;
                    end else begin
                        f_act = ACT_FAIL;
                    end
                end
                SC_OP: begin
                    if (is_op(c)) begin
                        f_append = 1'b1;
                    end else if (kw_res.hit) begin
                        f_emit   = 1'b1;
                        f_cls    = TC_KEYWORD;
                        f_kw     = kw_res.id;
                        f_finish = 1'b1;
                        f_act    = ACT_RPT;
                    end else begin
                        f_act = ACT_FAIL;
                    end
                end
                SC_TEXT: begin
                    if (c == 8'd0) begin
                        f_act = ACT_FAIL;
                    end else begin
                        f_append = 1'b1;
                        if (c == "\\") begin
                            f_scan = SC_ESC;
                        end else if (c == "'") begin
                            f_emit   = 1'b1;
                            f_cls    = TC_TEXT;
                            f_len    = fill_ext[6:0] + 7'd1;
                            f_finish = 1'b1;
                        end
                    end
                end
                SC_ESC: begin
                    if (c == 8'd0) begin
                        f_act = ACT_FAIL;
                    end else begin
                        f_append = 1'b1;
                        f_scan   = SC_TEXT;
                    end
                end
                SC_COMMENT: begin
                    if (c == 8'd10) begin
                        f_bump = 1'b1;
                        f_scan = SC_START;
                    end else if (c == 8'd0) begin
                        f_emit   = 1'b1;
                        f_cls    = TC_END;
                        f_start  = r_p;
                        f_len    = '0;
                        f_finish = 1'b1;
                        f_act    = ACT_END;
                    end
                end
                default: begin
                    f_finish = 1'b1;
                    f_act    = ACT_RPT;
                end
            endcase
            // A failed match gives its first byte alone and replays the rest.
            if (f_act == ACT_FAIL) begin
                f_emit   = 1'b1;
                f_cls    = TC_CHAR;
                f_ch     = r_first;
                f_len    = 7'd1;
                f_finish = 1'b1;
            end
        end
    end

    assign emit_push = f_emit && (r_res_cnt < 7'(RESULT_CAP));
    assign emit_ok   = !r_hold_v || out_free;
    assign feed_go   = (r_ctl == CTL_FEED) && (!emit_push || emit_ok);
    assign n_p       = (f_act == ACT_FAIL) ? st + 16'd1 : r_p + 16'd1;

    // History memory: written on input transfers, read back for replay.
    always_ff @(posedge i_clk) begin
        if (in_acc && !eff_ended) begin
            r_hist[eff_off[AW-1:0]] <= i_in_byte;
        end
        if (r_ctl == CTL_READ) begin
            r_rd <= r_hist[r_p[AW-1:0]];
        end
    end

    // Sequencer and scanner state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl      <= CTL_IDLE;
            r_scan     <= SC_START;
            r_fill     <= '0;
            r_line     <= 16'd1;
            r_off      <= '0;
            r_ended    <= 1'b0;
            r_from_mem <= 1'b0;
            r_res_cnt  <= '0;
        end else begin
            unique case (r_ctl)
                CTL_IDLE: begin
                    if (in_acc) begin
                        if (i_new_query) begin
                            r_scan  <= SC_START;
                            r_fill  <= '0;
                            r_line  <= 16'd1;
                            r_off   <= '0;
                            r_ended <= 1'b0;
                        end
                        if (!eff_ended) begin
                            r_byte     <= i_in_byte;
                            r_p        <= eff_off;
                            r_from_mem <= 1'b0;
                            r_res_cnt  <= '0;
                            r_ctl      <= CTL_FEED;
                        end
                    end
                end
                CTL_READ: begin
                    r_from_mem <= 1'b1;
                    r_ctl      <= CTL_FEED;
                end
                CTL_FEED: begin
                    if (feed_go) begin
                        r_scan <= f_finish ? SC_START : f_scan;
                        if (f_finish) begin
                            r_fill <= '0;
                        end else if (f_append) begin
                            r_fill <= r_fill + FW'(1);
                        end
                        if (f_append && r_fill == '0) begin
                            r_first <= c;
                        end
                        if (f_bump && r_line != 16'hFFFF) begin
                            r_line <= r_line + 16'd1;
                        end
                        if (emit_push) begin
                            r_res_cnt <= r_res_cnt + 7'd1;
                        end
                        priority case (f_act)
                            ACT_END: begin
                                r_ended <= 1'b1;
                                r_off   <= r_off + 16'd1;
                                r_ctl   <= CTL_IDLE;
                            end
                            ACT_RPT: begin
                                r_ctl <= CTL_FEED;
                            end
                            default: begin
                                if (f_act == ACT_ADV && r_p == r_off) begin
                                    r_off <= r_off + 16'd1;
                                    r_ctl <= CTL_IDLE;
                                end else if (n_p == r_p) begin
                                    r_ctl <= CTL_FEED;
                                end else begin
                                    r_p   <= n_p;
                                    r_ctl <= CTL_READ;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    r_ctl <= CTL_IDLE;
                end
            endcase
        end
    end

    // Staging and output registers. The staged token moves on as not last when
    // a newer one arrives, and as last once the step has ended.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
            if (r_ctl == CTL_IDLE && r_hold_v && out_free) begin
                r_out_v     <= 1'b1;
                r_out_cls   <= r_hold_cls;
                r_out_kw    <= r_hold_kw;
                r_out_ch    <= r_hold_ch;
                r_out_start <= r_hold_start;
                r_out_len   <= r_hold_len;
                r_out_line  <= r_hold_line;
                r_out_last  <= 1'b1;
                r_hold_v    <= 1'b0;
            end else if (feed_go && emit_push) begin
                if (r_hold_v) begin
                    r_out_v     <= 1'b1;
                    r_out_cls   <= r_hold_cls;
                    r_out_kw    <= r_hold_kw;
                    r_out_ch    <= r_hold_ch;
                    r_out_start <= r_hold_start;
                    r_out_len   <= r_hold_len;
                    r_out_line  <= r_hold_line;
                    r_out_last  <= 1'b0;
                end
                r_hold_v     <= 1'b1;
                r_hold_cls   <= f_cls;
                r_hold_kw    <= f_kw;
                r_hold_ch    <= f_ch;
                r_hold_start <= f_start;
                r_hold_len   <= f_len;
                r_hold_line  <= r_line;
            end
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_token_class  = r_out_cls;
    assign o_keyword_id   = r_out_kw;
    assign o_char_value   = r_out_ch;
    assign o_token_start  = r_out_start;
    assign o_token_length = r_out_len;
    assign o_line_number  = r_out_line;
    assign o_last_result  = r_out_last;

endmodule
